[src/stts_pkg.sv]
// Shared types, codes and Q16.16 arithmetic helpers for the transform stack.
// No dependencies; compile first.
package stts_pkg;

  localparam int unsigned QW = 32;
  localparam logic signed [QW-1:0] Q_ONE = 32'sh0001_0000;
  localparam logic signed [QW-1:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [QW-1:0] Q_MIN = 32'sh8000_0000;

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_QUERY = 2'd2,
    OP_APPLY = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STS_OK    = 2'd0,
    STS_FULL  = 2'd1,
    STS_EMPTY = 2'd2,
    STS_SAT   = 2'd3
  } status_t;

  // One stacked transform: p' = scale * p + shift
  typedef struct packed {
    logic signed [QW-1:0] scale;
    logic signed [QW-1:0] shift_x;
    logic signed [QW-1:0] shift_y;
  } xform_t;

  localparam xform_t XFORM_IDENTITY = '{scale: Q_ONE, shift_x: '0, shift_y: '0};

  typedef struct packed {
    logic                 sat;
    logic signed [QW-1:0] val;
  } qres_t;

  // Full product, floor shift by 16, saturate to 32 bits.
  function automatic qres_t qmul(input logic signed [QW-1:0] a,
                                 input logic signed [QW-1:0] b);
    logic signed [2*QW-1:0] p;
    logic signed [2*QW-17:0] q;
    qres_t r;
    p = a * b;
    q = p[2*QW-1:16];
    if ((&q[2*QW-17:QW-1]) || !(|q[2*QW-17:QW-1])) begin
      r.sat = 1'b0;
      r.val = q[QW-1:0];
    end else begin
      r.sat = 1'b1;
      r.val = q[2*QW-17] ? Q_MIN : Q_MAX;
    end
    return r;
  endfunction

  // Exact sum, saturate to 32 bits.
  function automatic qres_t qadd(input logic signed [QW-1:0] a,
                                 input logic signed [QW-1:0] b);
    logic signed [QW:0] s;
    qres_t r;
    s = {a[QW-1], a} + {b[QW-1], b};
    if (s[QW] == s[QW-1]) begin
      r.sat = 1'b0;
      r.val = s[QW-1:0];
    end else begin
      r.sat = 1'b1;
      r.val = s[QW] ? Q_MIN : Q_MAX;
    end
    return r;
  endfunction

  // s * v + t with saturation after the product and after the sum.
  function automatic qres_t qmac(input logic signed [QW-1:0] s,
                                 input logic signed [QW-1:0] v,
                                 input logic signed [QW-1:0] t);
    qres_t m;
    qres_t a;
    qres_t r;
    m = qmul(s, v);
    a = qadd(m.val, t);
    r.sat = m.sat | a.sat;
    r.val = a.val;
    return r;
  endfunction

endpackage

[src/stts_if.sv]
// Valid/ready channel interfaces for the transform stack: command and response.
// Depends on nothing; compile after stts_pkg.
interface stts_cmd_if;
  logic               valid;
  logic               ready;
  logic [1:0]         opcode;
  logic signed [31:0] new_scale;
  logic signed [31:0] new_shift_x;
  logic signed [31:0] new_shift_y;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;

  modport source (output valid, opcode, new_scale, new_shift_x, new_shift_y,
                  point_x, point_y, input ready);
  modport sink   (input valid, opcode, new_scale, new_shift_x, new_shift_y,
                  point_x, point_y, output ready);
endinterface

interface stts_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] top_scale;
  logic signed [31:0] top_shift_x;
  logic signed [31:0] top_shift_y;
  logic signed [31:0] mapped_x;
  logic signed [31:0] mapped_y;
  logic [3:0]         stack_level;
  logic [1:0]         status;

  modport source (output valid, top_scale, top_shift_x, top_shift_y, mapped_x,
                  mapped_y, stack_level, status, input ready);
  modport sink   (input valid, top_scale, top_shift_x, top_shift_y, mapped_x,
                  mapped_y, stack_level, status, output ready);
endinterface

[src/scale_translate_transform_stack.sv]
// Top level of the scale-plus-translation transform stack.
// Depends on stts_pkg and the channel interfaces in stts_if.
//
// Usage:
//   cmd carries one operation per word: push a transform (composed with the
//   current top), pop, query the top, or map a point through the top. rsp
//   returns one word per command: the top after the operation, the mapped
//   point (zero unless apply), the stack level and a status code.
//   All values are signed Q16.16; an empty stack reads as identity.
// Timing:
//   A command is captured in an input register, evaluated combinationally
//   and lands in the response register. One word per cycle sustained
//   while rsp is ready. The current top is held in registers and the slot
//   below it is prefetched from the slot memory with a registered read, so
//   consecutive push/pop words can be taken back to back without waiting.
// Reset:
//   rst (synchronous) empties the stack and drops words in flight; slot
//   contents are not cleared, only slots below the level are ever used.
// Stall:
//   While rsp is stalled the response word holds; the input register keeps
//   one more word, after which cmd.ready drops.
module scale_translate_transform_stack #(
  parameter int unsigned STACK_DEPTH = 8
) (
  input  logic      clk,
  input  logic      rst,
  stts_cmd_if.sink  cmd,
  stts_rsp_if.source rsp
);
  import stts_pkg::*;

  localparam int unsigned LVL_W = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AW    = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  // input register
  logic               in_valid;
  op_t                in_op;
  logic signed [31:0] in_new_scale;
  logic signed [31:0] in_new_shift_x;
  logic signed [31:0] in_new_shift_y;
  logic signed [31:0] in_point_x;
  logic signed [31:0] in_point_y;

  // stack state
  logic [LVL_W-1:0]   level;
  logic [LVL_W-1:0]   level_next;
  xform_t             top;
  xform_t             top_next;
  xform_t             below;
  xform_t             slots [STACK_DEPTH];

  // response register
  logic               out_valid;
  xform_t             out_top;
  logic signed [31:0] out_mapped_x;
  logic signed [31:0] out_mapped_y;
  logic [3:0]         out_level;
  status_t            out_status;

  logic               advance;
  logic               is_full;
  logic               is_empty;
  logic               do_push;
  logic [AW-1:0]      wr_addr;
  logic [AW-1:0]      rd_addr;
  logic [LVL_W:0]     rd_idx;
  logic [LVL_W+3:0]   level_ext;
  logic signed [31:0] mul_x;
  logic signed [31:0] mul_y;
  qres_t              prod_scale;
  qres_t              mac_x;
  qres_t              mac_y;
  logic signed [31:0] mapped_x_next;
  logic signed [31:0] mapped_y_next;
  status_t            status_next;

  assign advance   = in_valid && (!out_valid || rsp.ready);
  assign cmd.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (cmd.ready) begin
      in_valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ready && cmd.valid) begin
      in_op          <= op_t'(cmd.opcode);
      in_new_scale   <= cmd.new_scale;
      in_new_shift_x <= cmd.new_shift_x;
      in_new_shift_y <= cmd.new_shift_y;
      in_point_x     <= cmd.point_x;
      in_point_y     <= cmd.point_y;
    end
  end

  assign is_full  = (level == LVL_W'(STACK_DEPTH));
  assign is_empty = (level == '0);

  // Push and apply share the two multiply-add paths.
  assign mul_x      = (in_op == OP_PUSH) ? in_new_shift_x : in_point_x;
  assign mul_y      = (in_op == OP_PUSH) ? in_new_shift_y : in_point_y;
  assign prod_scale = qmul(top.scale, in_new_scale);
  assign mac_x      = qmac(top.scale, mul_x, top.shift_x);
  assign mac_y      = qmac(top.scale, mul_y, top.shift_y);

  always_comb begin
    level_next    = level;
    top_next      = top;
    mapped_x_next = '0;
    mapped_y_next = '0;
    status_next   = STS_OK;
    do_push       = 1'b0;
    unique case (in_op)
      OP_PUSH: begin
        if (is_full) begin
          status_next = STS_FULL;
        end else begin
          do_push          = 1'b1;
          level_next       = level + 1'b1;
          top_next.scale   = prod_scale.val;
          top_next.shift_x = mac_x.val;
          top_next.shift_y = mac_y.val;
          if (prod_scale.sat || mac_x.sat || mac_y.sat) begin
            status_next = STS_SAT;
          end
        end
      end
      OP_POP: begin
        if (is_empty) begin
          status_next = STS_EMPTY;
        end else begin
          level_next = level - 1'b1;
          top_next   = (level == LVL_W'(1)) ? XFORM_IDENTITY : below;
        end
      end
      OP_QUERY: begin
      end
      OP_APPLY: begin
        mapped_x_next = mac_x.val;
        mapped_y_next = mac_y.val;
        if (mac_x.sat || mac_y.sat) begin
          status_next = STS_SAT;
        end
      end
      default: begin
      end
    endcase
  end

  // Keep the slot under the new top ready for the next pop.
  assign rd_idx  = {1'b0, level_next} - (LVL_W + 1)'(2);
  assign rd_addr = rd_idx[AW-1:0];
  assign wr_addr = level[AW-1:0];

  always_ff @(posedge clk) begin
    if (advance && do_push) begin
      slots[wr_addr] <= top_next;
    end
    if (advance) begin
      below <= slots[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level <= '0;
      top   <= XFORM_IDENTITY;
    end else if (advance) begin
      level <= level_next;
      top   <= top_next;
    end
  end

  assign level_ext = {4'b0000, level_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_top      <= top_next;
      out_mapped_x <= mapped_x_next;
      out_mapped_y <= mapped_y_next;
      out_level    <= level_ext[3:0];
      out_status   <= status_next;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.top_scale   = out_top.scale;
  assign rsp.top_shift_x = out_top.shift_x;
  assign rsp.top_shift_y = out_top.shift_y;
  assign rsp.mapped_x    = out_mapped_x;
  assign rsp.mapped_y    = out_mapped_y;
  assign rsp.stack_level = out_level;
  assign rsp.status      = out_status;

  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    level <= LVL_W'(STACK_DEPTH))
    else $error("stack level beyond depth");

  a_empty_identity: assert property (@(posedge clk) disable iff (rst)
    level == '0 |-> top == XFORM_IDENTITY)
    else $error("empty stack does not hold identity");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    advance && in_op == OP_PUSH && !is_full |=> level == $past(level) + 1'b1)
    else $error("accepted push did not raise the level");

  a_pop_empty_rsp: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && out_status == STS_EMPTY |->
      out_level == 4'd0 && out_top == XFORM_IDENTITY)
    else $error("pop on empty reported a non-empty stack");

  a_stall_holds_state: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(level) && $stable(top))
    else $error("stack state moved without an evaluated word");

endmodule
